>>> rtl/csm_pkg.sv
// ----------------------------------------------------------------------------
// csm_pkg
// Shared types and constants for the carrier sense channel monitor.
// ----------------------------------------------------------------------------
package csm_pkg;

    localparam int unsigned BUFFER_DEPTH = 1024;
    localparam int unsigned POS_W        = $clog2(BUFFER_DEPTH) + 1;
    localparam int unsigned FRAME_ALIGN  = 16;
    localparam int unsigned ALIGN_BITS   = $clog2(FRAME_ALIGN);

    localparam int unsigned TICK_W   = 16;
    localparam int unsigned INDEX_W  = 10;
    localparam int unsigned LENGTH_W = 11;

    localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd17600;
    localparam logic [TICK_W-1:0] DELAY_RESET   = 16'd9000;

    localparam logic [POS_W-1:0] POS_FIRST = POS_W'(1);
    localparam logic [POS_W-1:0] POS_LAST  = POS_W'(BUFFER_DEPTH - 1);
    localparam logic [POS_W-1:0] POS_FULL  = POS_W'(BUFFER_DEPTH);

    localparam int unsigned APB_ADDR_W = 3;

    typedef enum logic [0:0] {
        REG_TIMEOUT = 1'b0,
        REG_DELAY   = 1'b1
    } reg_index_t;

    typedef enum logic [1:0] {
        MODE_IDLE      = 2'd0,
        MODE_BUSY      = 2'd1,
        MODE_COLLISION = 2'd2
    } channel_mode_t;

    typedef struct packed {
        logic [TICK_W-1:0] timeout_ticks;
        logic [TICK_W-1:0] sample_delay_ticks;
    } cfg_t;

    typedef struct packed {
        logic line_level;
        logic receive_enable;
    } request_t;

    typedef struct packed {
        channel_mode_t       channel_status;
        logic [1:0]          sample_count;
        logic                sample_bit;
        logic [INDEX_W-1:0]  sample_index;
        logic                frame_done;
        logic [LENGTH_W-1:0] frame_length;
    } result_t;

    function automatic logic [POS_W-1:0] pos_advance(input logic [POS_W-1:0] pos);
        return (pos >= POS_FULL) ? POS_FULL : pos + POS_W'(1);
    endfunction

    function automatic logic [INDEX_W-1:0] pos_slot(input logic [POS_W-1:0] pos);
        logic [POS_W-1:0] s;
        s = (pos > POS_LAST) ? POS_LAST : pos;
        return INDEX_W'(s);
    endfunction

endpackage

>>> rtl/csm_regs.sv
// ----------------------------------------------------------------------------
// csm_regs
// APB register file holding timeout and sample delay tick counts.
// ----------------------------------------------------------------------------
module csm_regs
    import csm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    logic [TICK_W-1:0] timeout_reg;
    logic [TICK_W-1:0] delay_reg;
    logic              wr_en;
    reg_index_t        sel;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign sel    = reg_index_t'(paddr[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RESET;
            delay_reg   <= DELAY_RESET;
        end else if (wr_en) begin
            case (sel)
                REG_TIMEOUT: timeout_reg <= pwdata[TICK_W-1:0];
                REG_DELAY:   delay_reg   <= pwdata[TICK_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb begin
        case (sel)
            REG_TIMEOUT: prdata = {{(32-TICK_W){1'b0}}, timeout_reg};
            REG_DELAY:   prdata = {{(32-TICK_W){1'b0}}, delay_reg};
            default:     prdata = '0;
        endcase
    end

    assign cfg.timeout_ticks      = timeout_reg;
    assign cfg.sample_delay_ticks = delay_reg;

endmodule

>>> rtl/csm_core.sv
// ----------------------------------------------------------------------------
// csm_core
// Channel state and per-tick update: timeout, edge capture, delayed sample.
// ----------------------------------------------------------------------------
module csm_core
    import csm_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     step,
    input  request_t req,
    input  cfg_t     cfg,
    output result_t  res
);

    logic [TICK_W-1:0] ticks_reg, ticks_next;
    logic              prev_level_reg, prev_level_next;
    channel_mode_t     mode_reg, mode_next;
    logic              tmo_armed_reg, tmo_armed_next;
    logic              smp_armed_reg, smp_armed_next;
    logic [POS_W-1:0]  wpos_reg, wpos_next;

    logic              edge_det;
    logic              timeout_hit;
    logic              sample_hit;
    logic [TICK_W-1:0] ticks_adv;
    logic [POS_W-1:0]  aligned;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ticks_reg      <= '0;
            prev_level_reg <= 1'b1;
            mode_reg       <= MODE_IDLE;
            tmo_armed_reg  <= 1'b0;
            smp_armed_reg  <= 1'b0;
            wpos_reg       <= POS_FIRST;
        end else if (step) begin
            ticks_reg      <= ticks_next;
            prev_level_reg <= prev_level_next;
            mode_reg       <= mode_next;
            tmo_armed_reg  <= tmo_armed_next;
            smp_armed_reg  <= smp_armed_next;
            wpos_reg       <= wpos_next;
        end
    end

    always_comb begin
        ticks_adv   = tmo_armed_reg ? ticks_reg + TICK_W'(1) : ticks_reg;
        timeout_hit = tmo_armed_reg && (ticks_adv == cfg.timeout_ticks);
        sample_hit  = tmo_armed_reg && smp_armed_reg
                      && (ticks_adv == cfg.sample_delay_ticks);
        edge_det    = req.line_level != prev_level_reg;
        aligned     = {wpos_reg[POS_W-1:ALIGN_BITS], {ALIGN_BITS{1'b0}}};

        ticks_next      = ticks_adv;
        prev_level_next = prev_level_reg;
        mode_next       = mode_reg;
        tmo_armed_next  = tmo_armed_reg;
        smp_armed_next  = smp_armed_reg;
        wpos_next       = wpos_reg;
        res             = '0;

        if (timeout_hit) begin
            tmo_armed_next = 1'b0;
            smp_armed_next = 1'b0;
            mode_next      = prev_level_reg ? MODE_IDLE : MODE_COLLISION;
            if (req.receive_enable) begin
                res.frame_done   = 1'b1;
                res.frame_length = LENGTH_W'(aligned);
                wpos_next        = POS_FIRST;
            end
        end

        if (sample_hit) begin
            smp_armed_next = 1'b0;
        end

        if (edge_det) begin
            prev_level_next = req.line_level;
            ticks_next      = '0;
            tmo_armed_next  = 1'b1;
            mode_next       = MODE_BUSY;
            if (req.receive_enable) begin
                smp_armed_next   = 1'b1;
                res.sample_index = pos_slot(wpos_next);
                res.sample_bit   = req.line_level;
                res.sample_count = 2'd1;
                wpos_next        = pos_advance(wpos_next);
            end
        end

        if (sample_hit && req.receive_enable) begin
            prev_level_next = req.line_level;
            if (!edge_det) begin
                res.sample_index = pos_slot(wpos_next);
                res.sample_bit   = req.line_level;
            end
            res.sample_count = res.sample_count + 2'd1;
            wpos_next        = pos_advance(wpos_next);
        end

        res.channel_status = mode_next;
    end

endmodule

>>> rtl/carrier_sense_channel_monitor.sv
// ----------------------------------------------------------------------------
// carrier_sense_channel_monitor
// Tracks a shared Manchester line one sample per tick: busy/idle/collision,
// bit capture at edges and mid-bit, frame length on timeout.
// ----------------------------------------------------------------------------
// channel   dir  fields
// s_axis    in   tdata: line_level[0], receive_enable[1]
// m_axis    out  tdata: status, count, bit, index, length; tlast: frame_done
// apb       in   timeout_ticks @0x0, sample_delay_ticks @0x4
//
// One request per cycle unless the output stalls; pipeline: input register ->
// state update -> result register, which loads when the request steps.
// Synchronous active-low reset; no clearing pass, ready right after reset.
// A stalled result holds; the input stage still takes one more request.
// ----------------------------------------------------------------------------
module carrier_sense_channel_monitor
    import csm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // tdata: [0] line_level, [1] receive_enable
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,
    // tdata: [1:0] channel_status, [3:2] sample_count, [4] sample_bit,
    //        [14:5] sample_index, [25:15] frame_length
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,
    output logic                  m_tlast,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    cfg_t     cfg;
    request_t req_reg, req_next;
    logic     in_vld_reg, in_vld_next;
    result_t  res_comb;
    result_t  res_reg;
    logic     out_vld_reg, out_vld_next;
    logic     step;

    csm_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    csm_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .req     (req_reg),
        .cfg     (cfg),
        .res     (res_comb)
    );

    assign step     = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || step;

    always_comb begin
        req_next     = req_reg;
        in_vld_next  = in_vld_reg;
        out_vld_next = out_vld_reg;
        if (step) begin
            in_vld_next = 1'b0;
        end
        if (s_tvalid && s_tready) begin
            req_next.line_level     = s_tdata[0];
            req_next.receive_enable = s_tdata[1];
            in_vld_next             = 1'b1;
        end
        if (m_tready) begin
            out_vld_next = 1'b0;
        end
        if (step) begin
            out_vld_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg <= req_next;
        if (step) begin
            res_reg <= res_comb;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tlast  = res_reg.frame_done;
    assign m_tdata  = {6'd0,
                       res_reg.frame_length,
                       res_reg.sample_index,
                       res_reg.sample_bit,
                       res_reg.sample_count,
                       res_reg.channel_status};

`ifndef SYNTHESIS
    a_status_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[1:0] != 2'd3))
        else $error("illegal channel status");

    a_length_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tdata[18:15] == 4'd0))
        else $error("frame length not aligned");

    a_no_bits_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[3:2] == 2'd0)) |-> (m_tdata[14:4] == 11'd0))
        else $error("sample fields set with no bits recorded");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        step |=> m_tvalid)
        else $error("processed request produced no result");
`endif

endmodule
